>>> sv/cbspl_pkg.sv
// ----------------------------------------------------------------------------
// cbspl_pkg - shared types and constants for the cubic B-spline evaluator
// Transaction payloads, the front-to-back job record, back-end state codes.
// ----------------------------------------------------------------------------
package cbspl_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned T_W       = 13;
  localparam int unsigned WGT_W     = 19;   // signed basis weight, 1.0 = 65536
  localparam int unsigned PROD_W    = COORD_W + WGT_W;
  localparam int unsigned NPTS      = 4;

  localparam logic [T_W-1:0] T_ONE  = 13'h1000;

  // Rounding offsets and weight offsets
  localparam logic [PROD_W-1:0]    RND12   = PROD_W'(12'h800);
  localparam logic [COORD_W-1:0]   RND4    = COORD_W'(4'h8);
  localparam logic [29:0]          RND12_S = 30'h800;
  localparam logic signed [WGT_W-1:0] W1_OFS = 19'sh0aaab;
  localparam logic signed [WGT_W-1:0] W2_OFS = 19'sh02aab;

  // floor(x / 6) = (x * RECIP6) >> RECIP_SH, exact for x < 2**17
  localparam logic [15:0] RECIP6   = 16'd43691;
  localparam int unsigned RECIP_SH = 18;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [T_W-1:0]            curve_t;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      evaluate;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] curve_x;
    logic signed [COORD_W-1:0] curve_y;
    logic signed [COORD_W-1:0] curve_z;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } pt3_t;

  // Index 0 is the oldest point
  typedef struct packed {
    logic                 flat;
    logic [T_W-1:0]       t;
    pt3_t [NPTS-1:0]      pts;
  } job_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SQR,
    BK_CUBE,
    BK_WGT,
    BK_TERM,
    BK_LAST,
    BK_OUT
  } bk_state_e;

endpackage

>>> sv/cbspl_front.sv
// ----------------------------------------------------------------------------
// cbspl_front - input side of the spline evaluator
// Holds the three-point window, clamps t, flags flat windows, queues jobs.
// ----------------------------------------------------------------------------
module cbspl_front import cbspl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  input  q_stat_t  q_stat_i,
  output logic     push_o,
  output job_t     push_job_o
);

  pt3_t win_q [3];
  pt3_t new_pt;
  logic accept;

  assign new_pt.x   = in_data_i.point_x;
  assign new_pt.y   = in_data_i.point_y;
  assign new_pt.z   = in_data_i.point_z;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = accept && in_data_i.evaluate;

  always_comb begin
    push_job_o.flat   = (win_q[0] == win_q[1]) && (win_q[1] == win_q[2]) &&
                        (win_q[2] == new_pt);
    push_job_o.t      = (in_data_i.curve_t > T_ONE) ? T_ONE : in_data_i.curve_t;
    push_job_o.pts[0] = win_q[0];
    push_job_o.pts[1] = win_q[1];
    push_job_o.pts[2] = win_q[2];
    push_job_o.pts[3] = new_pt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q[0] <= '0;
      win_q[1] <= '0;
      win_q[2] <= '0;
    end else if (accept) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= new_pt;
    end
  end

endmodule

>>> sv/cbspl_queue.sv
// ----------------------------------------------------------------------------
// cbspl_queue - short job queue between front and back
// Register-based FIFO; push ignored when full, pop ignored when empty.
// ----------------------------------------------------------------------------
module cbspl_queue import cbspl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  job_t    push_job_i,
  input  logic    pop_i,
  output job_t    head_o,
  output q_stat_t stat_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   cnt_q;
  logic              do_push, do_pop;

  assign stat_o.full      = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign stat_o.not_empty = (cnt_q != '0);
  assign do_push          = push_i && !stat_o.full;
  assign do_pop           = pop_i && stat_o.not_empty;
  assign head_o           = mem_q[rd_ptr_q];

  function automatic logic [QPTR_W-1:0] nxt(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= nxt(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= nxt(rd_ptr_q);
      if (do_push && !do_pop)      cnt_q <= cnt_q + (QPTR_W+1)'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_job_i;
  end

endmodule

>>> sv/cbspl_back.sv
// ----------------------------------------------------------------------------
// cbspl_back - evaluation side of the spline evaluator
// Builds basis weights in three steps, then one term per step on x/y/z lanes.
// ----------------------------------------------------------------------------
module cbspl_back import cbspl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      head_i,
  input  q_stat_t   q_stat_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  bk_state_e state_q, state_d;

  job_t                     job_q;
  logic [1:0]               idx_q;
  logic [16:0]              t2_q, u2_q, t3_q, u3_q;
  logic signed [WGT_W-1:0]  w_q [NPTS];
  logic signed [PROD_W-1:0] px_q, py_q, pz_q;
  logic signed [COORD_W-1:0] ax_q, ay_q, az_q;
  logic                     out_valid_q;
  out_item_t                out_data_q;

  logic out_free, ld_job, ld_sqr, ld_cube, ld_wgt, ld_term, ld_acc, ld_out;

  // rounded 12-bit product, cut to 32 bits, rounded and shifted right by 4
  function automatic logic signed [COORD_W-1:0] term(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0]  r;
    logic [COORD_W-1:0] c;
    r = $unsigned(p) + RND12;
    c = r[COORD_W+11:12] + RND4;
    return $signed(c) >>> 4;
  endfunction

  // rounded 12-bit multiply of two non-negative values below 2**17 and 2**13
  function automatic logic [16:0] fmul_u(input logic [16:0] a, input logic [T_W-1:0] b);
    logic [29:0] m;
    m = (30'(a) * 30'(b)) + RND12_S;
    return m[28:12];
  endfunction

  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (q_stat_i.not_empty) state_d = head_i.flat ? BK_OUT : BK_SQR;
      BK_SQR:  state_d = BK_CUBE;
      BK_CUBE: state_d = BK_WGT;
      BK_WGT:  state_d = BK_TERM;
      BK_TERM: if (idx_q == 2'd3) state_d = BK_LAST;
      BK_LAST: state_d = BK_OUT;
      BK_OUT:  if (out_free) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ld_job  = 1'b0;
    ld_sqr  = 1'b0;
    ld_cube = 1'b0;
    ld_wgt  = 1'b0;
    ld_term = 1'b0;
    ld_acc  = 1'b0;
    ld_out  = 1'b0;
    case (state_q)
      BK_IDLE: ld_job  = q_stat_i.not_empty;
      BK_SQR:  ld_sqr  = 1'b1;
      BK_CUBE: ld_cube = 1'b1;
      BK_WGT:  ld_wgt  = 1'b1;
      BK_TERM: begin
        ld_term = 1'b1;
        ld_acc  = (idx_q != 2'd0);
      end
      BK_LAST: ld_acc  = 1'b1;
      BK_OUT:  ld_out  = out_free;
      default: ;
    endcase
  end

  assign pop_o = ld_job;

  // weights
  logic [16:0]             t4, s0, hf2;
  logic [T_W-1:0]          u;
  logic [32:0]             d0, d3;
  logic signed [WGT_W-1:0] w0, w1, w2, w3;

  always_comb begin
    t4  = {job_q.t, 4'b0};
    u   = T_ONE - job_q.t;
    s0  = 17'((18'(t3_q) + 18'd1) >> 1);
    hf2 = 17'((18'(t2_q) + 18'd1) >> 1);
    d0  = 33'(u3_q) * 33'(RECIP6);
    d3  = 33'(t3_q) * 33'(RECIP6);
    w0  = WGT_W'(d0[32:RECIP_SH]);
    w3  = WGT_W'(d3[32:RECIP_SH]);
    w2  = $signed(WGT_W'(hf2)) - $signed(WGT_W'(s0)) +
          $signed(WGT_W'({job_q.t, 3'b0})) + W2_OFS;
    w1  = $signed(WGT_W'(s0)) - $signed(WGT_W'(t2_q)) + W1_OFS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (ld_wgt)       idx_q <= '0;
      else if (ld_term) idx_q <= idx_q + 2'd1;
      out_valid_q <= ld_out || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_job) begin
      job_q <= head_i;
      ax_q  <= head_i.flat ? head_i.pts[0].x : '0;
      ay_q  <= head_i.flat ? head_i.pts[0].y : '0;
      az_q  <= head_i.flat ? head_i.pts[0].z : '0;
    end
    if (ld_sqr) begin
      t2_q <= fmul_u(t4, job_q.t);
      u2_q <= fmul_u({u, 4'b0}, u);
    end
    if (ld_cube) begin
      t3_q <= fmul_u(t2_q, job_q.t);
      u3_q <= fmul_u(u2_q, u);
    end
    if (ld_wgt) begin
      w_q[0] <= w0;
      w_q[1] <= w1;
      w_q[2] <= w2;
      w_q[3] <= w3;
    end
    if (ld_term) begin
      px_q <= PROD_W'(job_q.pts[idx_q].x) * PROD_W'(w_q[idx_q]);
      py_q <= PROD_W'(job_q.pts[idx_q].y) * PROD_W'(w_q[idx_q]);
      pz_q <= PROD_W'(job_q.pts[idx_q].z) * PROD_W'(w_q[idx_q]);
    end
    if (ld_acc) begin
      ax_q <= ax_q + term(px_q);
      ay_q <= ay_q + term(py_q);
      az_q <= az_q + term(pz_q);
    end
    if (ld_out) begin
      out_data_q.curve_x <= ax_q;
      out_data_q.curve_y <= ay_q;
      out_data_q.curve_z <= az_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> sv/cubic_bspline_point_eval.sv
// ----------------------------------------------------------------------------
// cubic_bspline_point_eval - 3D uniform cubic B-spline point evaluator
// Windowed control points in, interpolated 20.12 curve points out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i): each transaction
//   shifts one control point into the window. With evaluate set it also
//   requests the curve point at curve_t over the oldest three held points
//   plus the new one. Without evaluate no result transaction follows.
//   Output channel (out_valid_o / out_stall_i / out_data_o): one result
//   per evaluate transaction, in order, held steady while stalled.
// Sequence and throughput:
//   A general point passes from queue head to output register in order:
//   pop, two squaring/cubing steps, one weight step, four term steps
//   sharing one multiplier per lane, a final accumulate and the output
//   load. A flat window (all four points equal) goes straight from pop to
//   the output load. The back-end sequencer sets the rate, one job at a
//   time. Inputs without evaluate are taken every cycle unless the queue
//   is full; the two-entry job queue lets the front keep accepting while the back works.
// Reset:
//   Window points clear to zero, queue and output register empty.
// Stall:
//   A stalled result stays in the output register; the back end waits
//   with its next result and the queue fills, then in_stall_o rises.
// ----------------------------------------------------------------------------
module cubic_bspline_point_eval import cbspl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  q_stat_t q_stat;
  logic    push, pop;
  job_t    push_job, head_job;

  // front: window, clamp, flat detection
  cbspl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_job_o (push_job)
  );

  // decoupling queue
  cbspl_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .stat_o     (q_stat)
  );

  // back: weights, terms, output register
  cbspl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_job),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
